@@ rtl/sac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// Shared constants, command codes, victim classes and the state encoding.
// ----------------------------------------------------------------------------
package sac_pkg;

	localparam int SAC_NUM_SETS = 64;
	localparam int SAC_NUM_WAYS = 8;
	localparam int SAC_BLOCK_BYTES = 64;
	localparam int SAC_ADDR_BITS = 48;
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [2:0] {
		CMD_READ = 3'd0,
		CMD_WRITE = 3'd1,
		CMD_INVAL = 3'd2,
		CMD_PROBE = 3'd3,
		CMD_CLRPF = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		CLS_NONE = 3'd0,
		CLS_DEAD = 3'd1,
		CLS_RONLY = 3'd2,
		CLS_WONLY = 3'd3,
		CLS_RW = 3'd4
	} vclass_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOOK = 2'b10
	} state_t;

endpackage

@@ rtl/sac_set_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_set_mem
// One row per set holding all ways: tags and metadata, registered read.
// ----------------------------------------------------------------------------
module sac_set_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input logic clk,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0] rdata,
	input logic we,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input logic [WIDTH-1:0] wdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/set_assoc_cache_lru_line_classify_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_line_classify_top
// Tag and state array of a set-associative write-back LRU cache.
// ----------------------------------------------------------------------------
// For each transaction the set row is first read from the set memory,
// then looked up, updated and written back while the result is registered.
// No new transaction is taken until the last one is through. A second result
// register holds one finished result while the output result waits, so one
// more transaction can be taken during an output stall; the input stalls
// once that register is full. After reset a clearing pass writes every set
// row, one per cycle, during which no transaction is accepted.
module set_assoc_cache_lru_line_classify_top #(
	parameter int NUM_SETS = sac_pkg::SAC_NUM_SETS,
	parameter int NUM_WAYS = sac_pkg::SAC_NUM_WAYS,
	parameter int BLOCK_BYTES = sac_pkg::SAC_BLOCK_BYTES,
	parameter int ADDR_BITS = sac_pkg::SAC_ADDR_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] cmd,
	input logic [47:0] address,
	input logic is_prefetch,
	output logic out_valid,
	input logic out_ready,
	output logic hit,
	output logic removed,
	output logic needs_writeback,
	output logic [47:0] victim_address,
	output logic victim_dirty,
	output logic [2:0] victim_class,
	output logic [16:0] victim_accesses,
	output logic prefetch_flag,
	output logic counted
);
	import sac_pkg::*;

	localparam int OFF_W = $clog2(BLOCK_BYTES);
	localparam int SET_W = $clog2(NUM_SETS);
	localparam int SI_W = SET_W > 0 ? SET_W : 1;
	localparam int ABITS = ADDR_BITS < 48 ? ADDR_BITS : 48;
	localparam int TAG_W = ABITS - OFF_W - SET_W;
	localparam int RK_W = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;
	localparam int WAY_W = 1 + 1 + 1 + TAG_W + 2 * CNT_W + RK_W;
	localparam int ROW_W = WAY_W * NUM_WAYS;

	typedef struct packed {
		logic v;
		logic d;
		logic pf;
		logic [TAG_W-1:0] tag;
		logic [CNT_W-1:0] rd;
		logic [CNT_W-1:0] wr;
		logic [RK_W-1:0] rk;
	} way_t;

	typedef struct packed {
		logic hit;
		logic rem;
		logic wb;
		logic [47:0] va;
		logic dirty;
		logic [2:0] cls;
		logic [16:0] acc;
		logic pf;
		logic cnt;
	} res_t;

	logic warmup_q;
	state_t state_q;
	logic clr_q;
	logic [SET_W:0] clr_cnt_q;
	logic [2:0] cmd_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [SI_W-1:0] set_s1;
	logic pf_s1;
	logic [ROW_W-1:0] rdata, wdata_row, fwd_q, row_new;
	logic fwd_v_q;
	logic [SI_W-1:0] fwd_set_q;
	logic we;
	logic [SI_W-1:0] waddr, raddr;
	logic [47:0] amask;
	res_t res_c;
	res_t pb_q;
	logic pb_v_q;
	logic out_free;

	way_t ways [NUM_WAYS];
	way_t nways [NUM_WAYS];

	assign amask = (ABITS >= 48) ? {48{1'b1}} : ((48'd1 << ABITS) - 48'd1);
	logic [47:0] addr_m;
	assign addr_m = address & amask;
	assign raddr = (SET_W > 0) ? SI_W'(addr_m >> OFF_W) : '0;

	assign cfg_ready = 1'b1;
	assign in_ready = !clr_q && state_q == ST_IDLE && !pb_v_q;
	assign out_free = !out_valid || out_ready;

	sac_set_mem #(.DEPTH(NUM_SETS), .WIDTH(ROW_W)) u_mem (
		.clk(clk), .raddr(raddr), .rdata(rdata),
		.we(we), .waddr(waddr), .wdata(wdata_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= 1'b0;
			state_q <= ST_IDLE;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			fwd_v_q <= 1'b0;
			out_valid <= 1'b0;
			pb_v_q <= 1'b0;
		end else begin
			if (cfg_valid) warmup_q <= cfg_data;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (SET_W + 1)'(NUM_SETS - 1)) clr_q <= 1'b0;
			end
			if (state_q == ST_LOOK || pb_v_q) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (state_q == ST_LOOK) pb_v_q <= !out_free;
			else if (out_ready) pb_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid && in_ready) state_q <= ST_LOOK;
				ST_LOOK: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			fwd_v_q <= (state_q == ST_LOOK);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			tag_s1 <= TAG_W'(addr_m >> (OFF_W + SET_W));
			set_s1 <= raddr;
			pf_s1 <= is_prefetch;
		end
		if (state_q == ST_LOOK) begin
			fwd_q <= row_new;
			fwd_set_q <= set_s1;
		end
	end

	// Lookup and update of the set row.
	logic [ROW_W-1:0] row_cur;
	logic hit_c, inv_found;
	logic [RK_W-1:0] hw, iw, lw, tw;
	logic [RK_W-1:0] trk;
	way_t vic;
	logic o_hit, o_rem, o_wb, o_dirty, o_pf, o_cnt;
	logic [47:0] o_va;
	logic [2:0] o_cls;
	logic [16:0] o_acc;
	logic is_rw, upd;

	always_comb begin
		row_cur = (fwd_v_q && fwd_set_q == set_s1) ? fwd_q : rdata;
		for (int w = 0; w < NUM_WAYS; w++) ways[w] = row_cur[w*WAY_W +: WAY_W];
		hit_c = 1'b0; hw = '0; inv_found = 1'b0; iw = '0; lw = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (ways[w].v && ways[w].tag == tag_s1) begin
				hit_c = 1'b1; hw = RK_W'(w);
			end
			if (!ways[w].v) begin
				inv_found = 1'b1; iw = RK_W'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++)
			if (ways[w].rk == RK_W'(NUM_WAYS - 1)) lw = RK_W'(w);
		is_rw = cmd_s1 == CMD_READ || cmd_s1 == CMD_WRITE;
		tw = hit_c ? hw : (inv_found ? iw : lw);
		vic = ways[tw];
		trk = vic.rk;
		for (int w = 0; w < NUM_WAYS; w++) nways[w] = ways[w];
		o_hit = 1'b0; o_rem = 1'b0; o_wb = 1'b0; o_dirty = 1'b0; o_pf = 1'b0;
		o_cnt = 1'b0; o_va = '0; o_cls = CLS_NONE; o_acc = '0;
		upd = 1'b0;
		if (cmd_s1 <= CMD_CLRPF) o_hit = hit_c;
		if (is_rw) begin
			o_cnt = !warmup_q && !pf_s1;
			upd = 1'b1;
			for (int w = 0; w < NUM_WAYS; w++)
				if (ways[w].rk < trk) nways[w].rk = ways[w].rk + 1'b1;
			nways[tw].rk = '0;
			if (hit_c) begin
				if (cmd_s1 == CMD_WRITE) begin
					nways[tw].d = 1'b1;
					if (vic.wr != CNT_MAX) nways[tw].wr = vic.wr + 1'b1;
				end else if (vic.rd != CNT_MAX) nways[tw].rd = vic.rd + 1'b1;
			end else begin
				o_wb = vic.v;
				o_rem = vic.v;
				nways[tw].v = 1'b1;
				nways[tw].tag = tag_s1;
				nways[tw].d = cmd_s1 == CMD_WRITE;
				nways[tw].pf = pf_s1;
				nways[tw].rd = '0;
				nways[tw].wr = '0;
			end
		end else if (hit_c) begin
			case (cmd_s1)
				CMD_INVAL: begin
					upd = 1'b1; o_rem = 1'b1;
					nways[tw].v = 1'b0; nways[tw].d = 1'b0; nways[tw].pf = 1'b0;
					nways[tw].rd = '0; nways[tw].wr = '0;
				end
				CMD_PROBE: o_pf = vic.pf;
				CMD_CLRPF: begin
					upd = 1'b1; nways[tw].pf = 1'b0;
				end
				default: ;
			endcase
		end
		if (o_rem) begin
			o_dirty = vic.d;
			o_va = (48'(vic.tag) << (OFF_W + SET_W)) | (48'(set_s1) << OFF_W);
			if (SET_W == 0) o_va = 48'(vic.tag) << OFF_W;
			if (!warmup_q) begin
				if (vic.rd == '0 && vic.wr == '0) o_cls = CLS_DEAD;
				else if (vic.wr == '0) begin o_cls = CLS_RONLY; o_acc = 17'(vic.rd); end
				else if (vic.rd == '0) begin o_cls = CLS_WONLY; o_acc = 17'(vic.wr); end
				else begin o_cls = CLS_RW; o_acc = 17'(vic.rd) + 17'(vic.wr); end
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) row_new[w*WAY_W +: WAY_W] = nways[w];
		if (!upd) row_new = row_cur;
		res_c = {o_hit, o_rem, o_wb, o_va, o_dirty, o_cls, o_acc, o_pf, o_cnt};
	end

	always_comb begin
		way_t iv;
		iv = '0;
		if (clr_q) begin
			we = 1'b1;
			waddr = SI_W'(clr_cnt_q);
			for (int w = 0; w < NUM_WAYS; w++) begin
				iv.rk = RK_W'(w);
				wdata_row[w*WAY_W +: WAY_W] = iv;
			end
		end else begin
			we = state_q == ST_LOOK;
			waddr = set_s1;
			wdata_row = row_new;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK && !out_free) pb_q <= res_c;
		if (state_q == ST_LOOK && out_free) begin
			{hit, removed, needs_writeback, victim_address, victim_dirty, victim_class,
				victim_accesses, prefetch_flag, counted} <= res_c;
		end else if (pb_v_q && out_ready) begin
			{hit, removed, needs_writeback, victim_address, victim_dirty, victim_class,
				victim_accesses, prefetch_flag, counted} <= pb_q;
		end
	end

	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ready) else $error("accept during clear");
	a_look_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOK |=> out_valid) else $error("result missing");
	a_wb_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && needs_writeback |-> removed) else $error("writeback without removal");
	a_pb_out: assert property (@(posedge clk) disable iff (!arst_n)
		pb_v_q |-> out_valid) else $error("held result without output result");
endmodule
